FILE: rtl/sws_pkg.sv
// Shared constants and types of the sliding window frame parser.
`timescale 1ns / 1ps
package sws_pkg;

   localparam int WINDOW_LEN       = 32;
   localparam int DIGITAL_CHANNELS = 8;
   localparam int ANALOG_CHANNELS  = 8;
   localparam int PAYLOAD_AT       = 3;
   localparam int MAX_RESULTS      = 8;

   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam int IDX_W  = $clog2(WINDOW_LEN);
   localparam int CNT_W  = $clog2(MAX_RESULTS);

   localparam int DIG_RES = (DIGITAL_CHANNELS < MAX_RESULTS) ? DIGITAL_CHANNELS : MAX_RESULTS;
   localparam int ANA_RES = (ANALOG_CHANNELS < MAX_RESULTS) ? ANALOG_CHANNELS : MAX_RESULTS;
   localparam int PAY_MAX_A = (DIG_RES > 2 * ANA_RES) ? DIG_RES : 2 * ANA_RES;
   localparam int PAY_BYTES = (PAY_MAX_A > 3) ? PAY_MAX_A : 3;

   // configuration register indexes
   localparam logic [2:0] CSR_START_CODE   = 3'd0;
   localparam logic [2:0] CSR_END_CODE     = 3'd1;
   localparam logic [2:0] CSR_INFO_TYPE    = 3'd2;
   localparam logic [2:0] CSR_DIGITAL_TYPE = 3'd3;
   localparam logic [2:0] CSR_ANALOG_TYPE  = 3'd4;
   localparam logic [2:0] CSR_GLOVE_DEV    = 3'd5;
   localparam logic [2:0] CSR_BALL_DEV     = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_DEVICE   = 2'd0;
   localparam logic [1:0] KIND_FIRMWARE = 2'd1;
   localparam logic [1:0] KIND_DIGITAL  = 2'd2;
   localparam logic [1:0] KIND_ANALOG   = 2'd3;

   // device kind values
   localparam logic [15:0] DEV_GLOVE = 16'd0;
   localparam logic [15:0] DEV_BALL  = 16'd1;
   localparam logic [15:0] DEV_OTHER = 16'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

FILE: rtl/sws_cell.sv
// One byte cell of the window row.
`timescale 1ns / 1ps
module sws_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  sws_pkg::cell_ctl_type ctl,
   input  sws_pkg::byte_type     rx_byte,
   input  sws_pkg::byte_type     neighbor_byte,
   output sws_pkg::byte_type     q
);
   import sws_pkg::*;

   byte_type data_ff;
   byte_type data_in;

   always_comb begin
      data_in = data_ff;
      priority if (ctl.clear) begin
         data_in = '0;
      end else if (ctl.load) begin
         data_in = rx_byte;
      end else if (ctl.shift) begin
         data_in = neighbor_byte;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign q = data_ff;

endmodule

FILE: rtl/sws_window.sv
// Window row: fill counter and a chain of byte cells that shifts left when full.
`timescale 1ns / 1ps
module sws_window (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic                                   clr_en,
   input  sws_pkg::byte_type                      rx_byte,
   output logic [sws_pkg::WINDOW_LEN-1:0][7:0]    win
);
   import sws_pkg::*;

   logic [FILL_W-1:0] fill_count_ff;
   logic [FILL_W-1:0] fill_count_in;
   logic              full;

   assign full = (fill_count_ff == FILL_W'(WINDOW_LEN));

   always_comb begin
      fill_count_in = fill_count_ff;
      if (clr_en) begin
         fill_count_in = '0;
      end else if (wr_en && !full) begin
         fill_count_in = fill_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < WINDOW_LEN; i++) begin : g_cell
         cell_ctl_type ctl;
         byte_type     nb;

         assign ctl.clear = clr_en;
         assign ctl.load  = wr_en && !full && (fill_count_ff == FILL_W'(i));
         assign ctl.shift = wr_en && full;

         if (i == WINDOW_LEN - 1) begin : g_tail
            assign nb = rx_byte;
         end else begin : g_body
            assign nb = win[i + 1];
         end

         sws_cell u_cell (
            .clock         (clock),
            .reset         (reset),
            .ctl           (ctl),
            .rx_byte       (rx_byte),
            .neighbor_byte (nb),
            .q             (win[i])
         );
      end
   endgenerate

endmodule

FILE: rtl/sliding_window_frame_parser.sv
// Top level: frame test, payload shift line and result sequencer.
//
//  channel | dir | handshake               | contents
//  req     | in  | req_tvalid/req_tready   | tdata: data_byte; tuser: action (1 = clear)
//  rsp     | out | rsp_tvalid/rsp_tready   | tdata: channel, value, value_minor; tuser: kind
//  csr     | in  | csr_valid/csr_ready     | csr_index, csr_wdata; always ready
//
// A clear request empties the window row. A data byte first shifts or fills
// the window row, then the frame test runs on the registered window. A
// matched frame then emits one result per cycle while rsp_tready is high,
// with at most 8 results per frame. A stalled result
// holds; no request is taken until the last result is taken.
// Reset zeroes the window cells and the fill count at once and restores the
// default codes.
`timescale 1ns / 1ps
module sliding_window_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] channel, [19:4] value, [27:20] value_minor, zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import sws_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_EMIT} state_type;
   typedef enum logic [1:0] {FR_INFO, FR_DIGITAL, FR_ANALOG} frame_type;

   // configuration
   byte_type start_code_ff, end_code_ff, info_type_ff, digital_type_ff;
   byte_type analog_type_ff, glove_dev_ff, ball_dev_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= 8'd240;
         end_code_ff     <= 8'd247;
         info_type_ff    <= 8'd1;
         digital_type_ff <= 8'd2;
         analog_type_ff  <= 8'd3;
         glove_dev_ff    <= 8'd1;
         ball_dev_ff     <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_CODE:   start_code_ff   <= csr_wdata;
            CSR_END_CODE:     end_code_ff     <= csr_wdata;
            CSR_INFO_TYPE:    info_type_ff    <= csr_wdata;
            CSR_DIGITAL_TYPE: digital_type_ff <= csr_wdata;
            CSR_ANALOG_TYPE:  analog_type_ff  <= csr_wdata;
            CSR_GLOVE_DEV:    glove_dev_ff    <= csr_wdata;
            CSR_BALL_DEV:     ball_dev_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // window row
   state_type                   state_ff, state_in;
   logic                        req_fire;
   logic [WINDOW_LEN-1:0][7:0]  win;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   sws_window u_window (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire && !req_tuser),
      .clr_en  (req_fire && req_tuser),
      .rx_byte (req_tdata),
      .win     (win)
   );

   // frame test on the registered window
   byte_type   typ, len, len_m1, end_byte;
   logic       len_ok, is_info, is_digital, is_analog, match;

   assign typ    = win[1];
   assign len    = win[2];
   assign len_m1 = len - 8'd1;
   assign len_ok = (len != 8'd0) && ({1'b0, len} <= 9'(WINDOW_LEN));
   assign end_byte = len_ok ? win[len_m1[IDX_W-1:0]] : '0;

   assign is_info    = (typ == info_type_ff);
   assign is_digital = (typ == digital_type_ff);
   assign is_analog  = (typ == analog_type_ff);
   assign match = (win[0] == start_code_ff) && (is_info || is_digital || is_analog)
                  && len_ok && (end_byte == end_code_ff);

   // sequencer
   frame_type                 mode_ff, mode_in;
   logic [CNT_W-1:0]          idx_ff, idx_in, last_idx_ff, last_idx_in;
   logic [PAY_BYTES-1:0][7:0] pay_ff, pay_in;
   logic [PAY_BYTES+1:0][7:0] pay_ext;
   logic                      rsp_last;

   assign pay_ext  = {16'd0, pay_ff};
   assign rsp_last = (idx_ff == last_idx_ff);

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      pay_in      = pay_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && !req_tuser) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            for (int k = 0; k < PAY_BYTES; k++) begin
               pay_in[k] = win[PAYLOAD_AT + k];
            end
            idx_in = '0;
            priority if (is_info) begin
               mode_in     = FR_INFO;
               last_idx_in = CNT_W'(1);
            end else if (is_digital) begin
               mode_in     = FR_DIGITAL;
               last_idx_in = CNT_W'(DIG_RES - 1);
            end else begin
               mode_in     = FR_ANALOG;
               last_idx_in = CNT_W'(ANA_RES - 1);
            end
            state_in = match ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_tready) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  // info frames read fixed slots; channel frames walk the line
                  if (mode_ff == FR_ANALOG) begin
                     for (int k = 0; k < PAY_BYTES; k++) begin
                        pay_in[k] = pay_ext[k + 2];
                     end
                  end else if (mode_ff == FR_DIGITAL) begin
                     for (int k = 0; k < PAY_BYTES; k++) begin
                        pay_in[k] = pay_ext[k + 1];
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff     <= mode_in;
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      pay_ff      <= pay_in;
   end

   // result fields
   logic [1:0]  rsp_kind;
   logic [3:0]  rsp_channel;
   logic [15:0] rsp_value, dev_kind;
   byte_type    rsp_minor;

   always_comb begin
      priority if (pay_ff[0] == glove_dev_ff) begin
         dev_kind = DEV_GLOVE;
      end else if (pay_ff[0] == ball_dev_ff) begin
         dev_kind = DEV_BALL;
      end else begin
         dev_kind = DEV_OTHER;
      end
   end

   always_comb begin
      rsp_channel = 4'(idx_ff);
      rsp_minor   = '0;
      unique case (mode_ff)
         FR_INFO: begin
            rsp_channel = '0;
            if (idx_ff == '0) begin
               rsp_kind  = KIND_DEVICE;
               rsp_value = dev_kind;
            end else begin
               rsp_kind  = KIND_FIRMWARE;
               rsp_value = {8'd0, pay_ff[1]};
               rsp_minor = pay_ff[2];
            end
         end
         FR_DIGITAL: begin
            rsp_kind  = KIND_DIGITAL;
            rsp_value = {8'd0, pay_ff[0]};
         end
         default: begin
            rsp_kind  = KIND_ANALOG;
            rsp_value = {pay_ff[0], pay_ff[1]};
         end
      endcase
   end

   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {4'd0, rsp_minor, rsp_value, rsp_channel};
   assign rsp_tuser  = rsp_kind;
   assign rsp_tlast  = rsp_last;

endmodule
